FILE: rtl/ach_pkg.sv
// Package: types, constants and AES helper functions for the chained-key hash.
`timescale 1ns / 1ps
package ach_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int SALT_BYTES  = 4;
    localparam int AES_ROUNDS  = 10;

    localparam logic [0:0] REG_SALT    = 1'd0;
    localparam logic [0:0] REG_OUT_LEN = 1'd1;

    typedef struct packed {
        logic [63:0] block_hi;
        logic [63:0] block_lo;
        logic        last_block;
        logic [4:0]  last_count;
    } t_in_req;

    typedef struct packed {
        logic [63:0] digest_hi;
        logic [63:0] digest_lo;
    } t_out_req;

    // Queue entry between front and core: padded block plus control.
    typedef struct packed {
        logic [127:0] blk;
        logic         last;
    } t_job;

    typedef logic [7:0] t_sbox_tab [256];
    localparam t_sbox_tab SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Byte i of a 128-bit block sits at bits [127-8i -: 8].
    function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
        return v[127-8*i -: 8];
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] rk,
                                                    input logic [7:0] rcon);
        logic [7:0] b [16];
        logic [7:0] t [4];
        logic [127:0] r;
        for (int i = 0; i < 16; i++) b[i] = get_byte(rk, i);
        t[0] = SBOX[b[13]] ^ rcon;
        t[1] = SBOX[b[14]];
        t[2] = SBOX[b[15]];
        t[3] = SBOX[b[12]];
        for (int i = 0; i < 4; i++) b[i] = b[i] ^ t[i];
        for (int i = 4; i < 16; i++) b[i] = b[i] ^ b[i-4];
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = b[i];
        return r;
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] st,
                                               input logic final_rnd);
        logic [7:0] s [16];
        logic [7:0] m [16];
        logic [7:0] a0, a1, a2, a3, t;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) s[i] = get_byte(st, i);
        for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++)
                m[4*c+k] = SBOX[s[4*((c+k)%4)+k]];
        if (!final_rnd) begin
            for (int c = 0; c < 4; c++) begin
                a0 = m[4*c]; a1 = m[4*c+1]; a2 = m[4*c+2]; a3 = m[4*c+3];
                t = a0 ^ a1 ^ a2 ^ a3;
                m[4*c]   = a0 ^ t ^ gf_double(a0 ^ a1);
                m[4*c+1] = a1 ^ t ^ gf_double(a1 ^ a2);
                m[4*c+2] = a2 ^ t ^ gf_double(a2 ^ a3);
                m[4*c+3] = a3 ^ t ^ gf_double(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = m[i];
        return r;
    endfunction

endpackage

FILE: rtl/aes_chained_key_hash.sv
// Top level: APB register file, front queue and AES back end.
`timescale 1ns / 1ps
// Hashes a message given as 16-byte blocks by chaining AES-128 keys; one digest
// comes out per final block. Each block runs its rounds in the single shared round
// unit (key expansion runs alongside), and with a queued block the next starts on
// the cycle the previous one finishes, so a new block is taken only as the last
// one completes. A two-entry input queue and a digest output register let input and
// output stall independently. Registers: salt at 0x0, output_bytes at 0x4.
module aes_chained_key_hash (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ach_pkg::t_in_req  i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output ach_pkg::t_out_req o_req,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ach_pkg::*;

    logic [31:0] r_salt;
    logic [4:0]  r_out_bytes;
    logic        w_job_valid, w_job_ready;
    t_job        w_job;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_salt      <= 32'd0;
            r_out_bytes <= 5'd16;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_SALT:    r_salt      <= pwdata;
                REG_OUT_LEN: r_out_bytes <= pwdata[4:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SALT:    prdata = r_salt;
            REG_OUT_LEN: prdata = {27'd0, r_out_bytes};
            default:     prdata = 32'd0;
        endcase
    end

    ach_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_req,
        .o_job_valid(w_job_valid), .i_job_ready(w_job_ready), .o_job(w_job)
    );

    ach_core u_core (
        .i_clk, .i_rst_n,
        .i_job_valid(w_job_valid), .o_job_ready(w_job_ready), .i_job(w_job),
        .i_salt(r_salt), .i_out_bytes(r_out_bytes),
        .o_valid, .i_ready, .o_req
    );
endmodule

FILE: rtl/ach_front.sv
// Front end: pads final blocks and pushes jobs into a two-entry queue.
`timescale 1ns / 1ps
module ach_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ach_pkg::t_in_req i_req,
    output logic            o_job_valid,
    input  logic            i_job_ready,
    output ach_pkg::t_job   o_job
);
    import ach_pkg::*;

    t_job        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_job        w_job;
    logic [4:0]  w_cnt;
    logic        w_push, w_pop;

    always_comb begin
        w_cnt = i_req.last_count;
        if (w_cnt == 5'd0 || w_cnt > 5'd16) w_cnt = 5'd16;
        w_job.last = i_req.last_block;
        w_job.blk  = {i_req.block_hi, i_req.block_lo};
        // zero bytes past the valid count of a final block
        if (i_req.last_block) begin
            for (int i = 0; i < 16; i++)
                if (5'(i) >= w_cnt) w_job.blk[127-8*i -: 8] = 8'h00;
        end
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_job_valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

FILE: rtl/ach_core.sv
// Back end: iterative AES-128 core with key chaining and digest output register.
`timescale 1ns / 1ps
module ach_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    input  ach_pkg::t_job    i_job,
    input  logic [31:0]      i_salt,
    input  logic [4:0]       i_out_bytes,
    output logic             o_valid,
    input  logic             i_ready,
    output ach_pkg::t_out_req o_req
);
    import ach_pkg::*;

    logic         r_busy, n_busy;
    logic [3:0]   r_rnd;
    logic [127:0] r_st, r_rk, r_chain;
    logic [7:0]   r_rcon;
    logic         r_last, r_mid;
    logic         r_ovalid;
    t_out_req     r_out;

    logic [127:0] w_key, w_rk_next, w_st_next;
    logic         w_start, w_done, w_out_free;
    logic [4:0]   w_keep;
    logic [127:0] w_dig;

    assign w_out_free  = !r_ovalid || i_ready;
    // accept a new job when idle or on the final round if nothing blocks it
    assign w_done      = r_busy && (r_rnd == 4'(AES_ROUNDS)) && (!r_last || w_out_free);
    assign o_job_ready = !r_busy || w_done;
    assign w_start     = i_job_valid && o_job_ready;

    // key chaining: next key is the previous result, or the salt after a final block
    always_comb begin
        w_rk_next = next_round_key(r_rk, r_rcon);
        w_st_next = aes_round(r_st, r_rnd == 4'(AES_ROUNDS)) ^ w_rk_next;
        if (w_done && !r_last) w_key = w_st_next;
        else if (r_mid && !w_done) w_key = r_chain;
        else if (w_done && r_last) w_key = {i_salt[7:0], i_salt[15:8], i_salt[23:16],
                                            i_salt[31:24], 96'd0};
        else if (r_mid) w_key = r_chain;
        else w_key = {i_salt[7:0], i_salt[15:8], i_salt[23:16], i_salt[31:24], 96'd0};
        w_keep = (i_out_bytes > 5'd16) ? 5'd16 : i_out_bytes;
        w_dig  = w_st_next;
        for (int i = 0; i < 16; i++)
            if (5'(i) >= w_keep) w_dig[127-8*i -: 8] = 8'h00;
        n_busy = w_start ? 1'b1 : (w_done ? 1'b0 : r_busy);
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_st   <= i_job.blk ^ w_key;
            r_rk   <= w_key;
            r_rcon <= 8'h01;
            r_last <= i_job.last;
        end else if (r_busy && r_rnd != 4'(AES_ROUNDS)) begin
            r_st   <= w_st_next;
            r_rk   <= w_rk_next;
            r_rcon <= gf_double(r_rcon);
        end
        if (w_done && !r_last) r_chain <= w_st_next;
        if (w_done && r_last) r_out <= {w_dig[127:64], w_dig[63:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rnd    <= 4'd0;
            r_mid    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (w_start) r_rnd <= 4'd1;
            else if (r_busy && r_rnd != 4'(AES_ROUNDS)) r_rnd <= r_rnd + 4'd1;
            if (w_done) r_mid <= !r_last;
            if (w_done && r_last) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    assign o_valid = r_ovalid;
    assign o_req   = r_out;
endmodule
